### hdl/bdc_pkg.sv
// Package for the bitmask dictionary code decompressor.
// Holds the word types, the command passed from parser to emitter and shared constants.
// No dependencies.
package bdc_pkg;

    localparam int WORD_BITS    = 32;
    localparam int DICT_ENTRIES = 8;
    localparam int IDX_BITS     = 3;
    localparam int CFG_IDX_BITS = 4;
    localparam int QUEUE_DEPTH  = 4;

    // Emitter modes carried by each command.
    localparam logic [1:0] MODE_DICT   = 2'd0;
    localparam logic [1:0] MODE_RAW    = 2'd1;
    localparam logic [1:0] MODE_REPEAT = 2'd2;

    typedef struct packed {
        logic [WORD_BITS-1:0] compressed_word;
        logic                 final_word;
    } in_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] decoded_word;
        logic                 run_last;
    } out_t;

    // One classified code: dictionary index with XOR pattern, a raw word or a repeat.
    typedef struct packed {
        logic [1:0]           mode;
        logic [IDX_BITS-1:0]  idx;
        logic [WORD_BITS-1:0] data;
        logic [1:0]           count;
        logic                 last;
    } cmd_t;

endpackage

### hdl/bdc_front.sv
// Stream parser: splits packed stream words into codes, one code a cycle unless stalled.
// Depends on bdc_pkg for the input word and command types.
module bdc_front
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  bdc_pkg::in_t in_data,
    output logic         cmd_valid,
    input  logic         cmd_ready,
    output bdc_pkg::cmd_t cmd_data
);

    localparam int BUF_BITS = 66;
    localparam int LOOK_BITS = 35;
    localparam logic [2:0] PREFIX_REPEAT = 3'd0;
    localparam logic [2:0] PREFIX_MASK   = 3'd1;
    localparam logic [2:0] PREFIX_FLIP1  = 3'd2;
    localparam logic [2:0] PREFIX_FLIP2  = 3'd3;
    localparam logic [2:0] PREFIX_FLIPS  = 3'd4;
    localparam logic [2:0] PREFIX_DIRECT = 3'd5;
    localparam logic [2:0] PREFIX_RAW    = 3'd6;
    localparam logic [2:0] PREFIX_PAD    = 3'd7;
    localparam logic [6:0] PREFIX_LEN    = 7'd3;
    localparam logic [31:0] TOP_BIT      = 32'h8000_0000;
    localparam logic [31:0] TOP_PAIR     = 32'hC000_0000;

    typedef struct packed {
        logic          ok;
        logic          pad;
        logic [5:0]    len;
        bdc_pkg::cmd_t cmd;
    } dec_t;

    // Classify the code at the top of the buffer, given how many bits are held.
    function automatic dec_t decode(input logic [LOOK_BITS-1:0] t, input logic [6:0] a);
        dec_t       d;
        logic [2:0] pre;
        pre = t[34:32];
        d.cmd = '0;
        d.len = 6'd0;
        case (pre)
            PREFIX_REPEAT:
            begin
                d.len = 6'd5;
                d.cmd.mode = bdc_pkg::MODE_REPEAT;
                d.cmd.count = t[31:30];
            end
            PREFIX_MASK:
            begin
                d.len = 6'd15;
                d.cmd.mode = bdc_pkg::MODE_DICT;
                d.cmd.idx = t[22:20];
                d.cmd.data = {t[26:23], 28'd0} >> t[31:27];
            end
            PREFIX_FLIP1:
            begin
                d.len = 6'd11;
                d.cmd.mode = bdc_pkg::MODE_DICT;
                d.cmd.idx = t[26:24];
                d.cmd.data = TOP_BIT >> t[31:27];
            end
            PREFIX_FLIP2:
            begin
                d.len = 6'd11;
                d.cmd.mode = bdc_pkg::MODE_DICT;
                d.cmd.idx = t[26:24];
                d.cmd.data = TOP_PAIR >> t[31:27];
            end
            PREFIX_FLIPS:
            begin
                d.len = 6'd16;
                d.cmd.mode = bdc_pkg::MODE_DICT;
                d.cmd.idx = t[21:19];
                d.cmd.data = (TOP_BIT >> t[31:27]) | (TOP_BIT >> t[26:22]);
            end
            PREFIX_DIRECT:
            begin
                d.len = 6'd6;
                d.cmd.mode = bdc_pkg::MODE_DICT;
                d.cmd.idx = t[31:29];
            end
            PREFIX_RAW:
            begin
                d.len = 6'd35;
                d.cmd.mode = bdc_pkg::MODE_RAW;
                d.cmd.data = t[31:0];
            end
            default:
            begin
                d.len = 6'd0;
            end
        endcase
        d.pad = (a >= PREFIX_LEN) && (pre == PREFIX_PAD);
        d.ok  = (a >= PREFIX_LEN) && (pre != PREFIX_PAD) && ({1'b0, d.len} <= a);
        return d;
    endfunction

    logic [BUF_BITS-1:0] buf_reg, buf_next;
    logic [6:0]          avail_reg, avail_next;
    logic                fin_reg, fin_next;
    logic                busy_reg, busy_next;

    dec_t                cur, nxt;
    logic [BUF_BITS-1:0] shift_buf;
    logic [6:0]          shift_avail;

    // Current code and the one behind it, so the last code of a word is known early.
    always_comb
    begin
        cur         = decode(buf_reg[BUF_BITS-1 -: LOOK_BITS], avail_reg);
        shift_buf   = buf_reg << cur.len;
        shift_avail = avail_reg - {1'b0, cur.len};
        nxt         = decode(shift_buf[BUF_BITS-1 -: LOOK_BITS], shift_avail);
    end

    assign in_ready  = !busy_reg;
    assign cmd_valid = busy_reg && cur.ok;

    always_comb
    begin
        cmd_data      = cur.cmd;
        cmd_data.last = !nxt.ok;
    end

    // Accept a word, then step through its codes; padding or the final word drops the rest.
    always_comb
    begin
        buf_next   = buf_reg;
        avail_next = avail_reg;
        fin_next   = fin_reg;
        busy_next  = busy_reg;
        if (!busy_reg)
        begin
            if (in_valid)
            begin
                buf_next   = buf_reg
                           | ({in_data.compressed_word, 34'd0} >> avail_reg);
                avail_next = avail_reg + 7'd32;
                fin_next   = in_data.final_word;
                busy_next  = 1'b1;
            end
        end
        else if (!cur.ok)
        begin
            busy_next = 1'b0;
            if (fin_reg || cur.pad)
            begin
                buf_next   = '0;
                avail_next = 7'd0;
            end
        end
        else if (cmd_ready)
        begin
            buf_next   = shift_buf;
            avail_next = shift_avail;
            if (!nxt.ok)
            begin
                busy_next = 1'b0;
                if (fin_reg || nxt.pad)
                begin
                    buf_next   = '0;
                    avail_next = 7'd0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg   <= '0;
            avail_reg <= 7'd0;
            fin_reg   <= 1'b0;
            busy_reg  <= 1'b0;
        end
        else
        begin
            buf_reg   <= buf_next;
            avail_reg <= avail_next;
            fin_reg   <= fin_next;
            busy_reg  <= busy_next;
        end
    end

endmodule

### hdl/bdc_queue.sv
// Short command queue between the parser and the emitter.
// Depends on bdc_pkg for the command type.
module bdc_queue
#(
    parameter int DEPTH = bdc_pkg::QUEUE_DEPTH
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  bdc_pkg::cmd_t push_data,
    output logic          pop_valid,
    input  logic          pop_ready,
    output bdc_pkg::cmd_t pop_data
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);
    localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(DEPTH);

    bdc_pkg::cmd_t       slot_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                do_push, do_pop;

    assign push_ready = (cnt_reg != FULL_CNT);
    assign pop_valid  = (cnt_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer wrap and fill count.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Slot storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### hdl/bdc_back.sv
// Word emitter: holds the dictionary and the previous word, turns commands into words.
// Depends on bdc_pkg for the command and output word types.
module bdc_back
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [bdc_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [bdc_pkg::WORD_BITS-1:0]        cfg_data,
    input  logic                                 cmd_valid,
    output logic                                 cmd_ready,
    input  bdc_pkg::cmd_t                        cmd_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output bdc_pkg::out_t                        out_data
);

    logic [bdc_pkg::WORD_BITS-1:0] dict_reg [bdc_pkg::DICT_ENTRIES];
    logic [bdc_pkg::WORD_BITS-1:0] prev_reg, prev_next;
    logic [1:0]                    rep_reg, rep_next;
    logic                          out_valid_reg, out_valid_next;
    bdc_pkg::out_t                 out_reg, out_next;

    logic                          load;
    logic                          rep_done;
    logic [bdc_pkg::WORD_BITS-1:0] result;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // A word moves into the output register whenever it is empty or being taken.
    assign load      = cmd_valid && (!out_valid_reg || out_ready);
    assign rep_done  = (cmd_data.mode != bdc_pkg::MODE_REPEAT) || (rep_reg == cmd_data.count);
    assign cmd_ready = load && rep_done;

    always_comb
    begin
        case (cmd_data.mode)
            bdc_pkg::MODE_RAW:    result = cmd_data.data;
            bdc_pkg::MODE_REPEAT: result = prev_reg;
            default:              result = dict_reg[cmd_data.idx] ^ cmd_data.data;
        endcase
    end

    // Output register, repeat counter and previous word.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        prev_next      = prev_reg;
        rep_next       = rep_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (load)
        begin
            out_valid_next        = 1'b1;
            out_next.decoded_word = result;
            out_next.run_last     = cmd_data.last && rep_done;
            prev_next             = result;
            rep_next              = rep_done ? 2'd0 : rep_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            prev_reg      <= '0;
            rep_reg       <= 2'd0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            prev_reg      <= prev_next;
            rep_reg       <= rep_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    // Dictionary words; writes beyond the last entry are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < bdc_pkg::DICT_ENTRIES; i++)
            begin
                dict_reg[i] <= '0;
            end
        end
        else if (cfg_we && (cfg_index < bdc_pkg::CFG_IDX_BITS'(bdc_pkg::DICT_ENTRIES)))
        begin
            dict_reg[cfg_index[bdc_pkg::IDX_BITS-1:0]] <= cfg_data;
        end
    end

endmodule

### hdl/bitmask_dictionary_code_decompressor_core.sv
// Top level of the bitmask dictionary code decompressor.
// Depends on bdc_pkg, bdc_front, bdc_queue and bdc_back.
//
// Channel   Signals                        Moves
// in        in_valid, in_ready, in_data     one packed stream word per handshake
// out       out_valid, out_ready, out_data  one decoded word per handshake
// cfg       cfg_we, cfg_index, cfg_data     one dictionary word per write
//
// The parser accepts a word, then steps through the codes in it one by one, holding
// in_ready low until it is through with the word, so it takes no new word meanwhile.
// The emitter gives one word per cycle unless stalled; a repeat gives one to four words.
// Reset clears the held stream bits, the previous word and the dictionary at once.
// The command queue lets the parser run ahead while the output side is stalled.
module bitmask_dictionary_code_decompressor_core
#(
    parameter int QUEUE_DEPTH = bdc_pkg::QUEUE_DEPTH
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  bdc_pkg::in_t                     in_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output bdc_pkg::out_t                    out_data,
    input  logic                             cfg_we,
    input  logic [bdc_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [bdc_pkg::WORD_BITS-1:0]    cfg_data
);

    logic          fq_valid, fq_ready;
    bdc_pkg::cmd_t fq_data;
    logic          qb_valid, qb_ready;
    bdc_pkg::cmd_t qb_data;

    // Parser front.
    bdc_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .cmd_valid (fq_valid),
        .cmd_ready (fq_ready),
        .cmd_data  (fq_data)
    );

    // Command queue.
    bdc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_data  (fq_data),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_data   (qb_data)
    );

    // Emitter back.
    bdc_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_valid (qb_valid),
        .cmd_ready (qb_ready),
        .cmd_data  (qb_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

### bench/bitmask_dictionary_code_decompressor_core_test.sv
// Self-checking bench for the bitmask dictionary code decompressor core.
// Drives packed stream words, predicts every decoded word and checks them in order.
// Depends on bdc_pkg and bitmask_dictionary_code_decompressor_core.
`timescale 1ns / 1ps

module bitmask_dictionary_code_decompressor_core_test;

    // Code prefixes of the packed stream.
    typedef enum logic [2:0] {
        CODE_REPEAT    = 3'b000,
        CODE_MASK      = 3'b001,
        CODE_ONE_FLIP  = 3'b010,
        CODE_PAIR_FLIP = 3'b011,
        CODE_TWO_FLIP  = 3'b100,
        CODE_DICT      = 3'b101,
        CODE_RAW       = 3'b110,
        CODE_PAD       = 3'b111
    } code_t;

    // Ways of filling the dictionary between phases.
    typedef enum int {FILL_ONES, FILL_ZEROS, FILL_RANDOM, FILL_STRIPES} dict_fill_t;

    typedef struct {
        logic [bdc_pkg::WORD_BITS-1:0] word;
        bit                            fin;
        bit                            pinned;
        int                            pin_count;
        logic [bdc_pkg::WORD_BITS-1:0] pin_value;
    } directed_row_t;

    localparam logic [bdc_pkg::CFG_IDX_BITS-1:0] REG_DICT_BASE    = 4'd0;
    localparam logic [bdc_pkg::CFG_IDX_BITS-1:0] REG_FIRST_UNUSED = 4'd8;
    localparam int PHASES          = 6;
    localparam int PHASE_WORDS     = 80;
    localparam int MAX_IDLE        = 13;
    localparam int SETTLE_CYCLES   = 100;
    localparam int HOLD_OFF_AFTER  = 400;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int WATCHDOG_LIMIT  = 2000;

    // Length of each code, prefix included; padding has none of its own.
    int code_bits_len [8] = '{5, 15, 11, 11, 16, 6, 35, 0};

    dict_fill_t phase_fill [PHASES] = '{FILL_ONES, FILL_ZEROS, FILL_RANDOM,
                                        FILL_STRIPES, FILL_RANDOM, FILL_RANDOM};
    int phase_gap   [PHASES] = '{MAX_IDLE, 0, MAX_IDLE, 0, MAX_IDLE, MAX_IDLE};
    int phase_stall [PHASES] = '{MAX_IDLE, 0, MAX_IDLE, MAX_IDLE, 0, MAX_IDLE};

    logic                             clk       = 1'b0;
    logic                             rst_n     = 1'b0;
    logic                             in_valid  = 1'b0;
    logic                             in_ready;
    bdc_pkg::in_t                     in_data   = '0;
    logic                             out_valid;
    logic                             out_ready = 1'b0;
    bdc_pkg::out_t                    out_data;
    logic                             cfg_we    = 1'b0;
    logic [bdc_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [bdc_pkg::WORD_BITS-1:0]    cfg_data  = '0;

    // Decoder state as the bench sees it.
    logic [bdc_pkg::WORD_BITS-1:0] dict_model [bdc_pkg::DICT_ENTRIES];
    logic [33:0]                   held_bits    = '0;
    int                            held_count   = 0;
    logic [bdc_pkg::WORD_BITS-1:0] last_emitted = '0;

    bdc_pkg::out_t word_results   [$];
    bdc_pkg::out_t expected_words [$];
    bit            stream_bits    [$];
    directed_row_t rows           [$];

    int mismatch_count     = 0;
    int results_seen       = 0;
    int stalled_cycles     = 0;
    int sender_gap_max     = MAX_IDLE;
    int receiver_stall_max = MAX_IDLE;

    bitmask_dictionary_code_decompressor_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic note_mismatch(string what);
        $display("mismatch at result %0d: %s", results_seen, what);
        mismatch_count++;
    endtask

    // Appends one row to the directed table.
    task automatic add_row(directed_row_t row);
        rows.insert(rows.size(), row);
    endtask

    // Reads n bits of the joined stream from position p, MSB first; past the end reads zero.
    function automatic logic [bdc_pkg::WORD_BITS-1:0] stream_field(logic [65:0] stream,
                                                                   int avail, int p, int n);
        logic [bdc_pkg::WORD_BITS-1:0] acc;
        acc = '0;
        for (int k = 0; k < n; k++)
        begin
            acc = {acc[bdc_pkg::WORD_BITS-2:0],
                   (p + k < avail) ? stream[avail - 1 - (p + k)] : 1'b0};
        end
        return acc;
    endfunction

    // Splits held bits plus one new word into codes and fills word_results.
    task automatic decode_stream_word(input bdc_pkg::in_t item);
        logic [65:0]                   stream;
        logic [2:0]                    prefix_bits;
        code_t                         prefix;
        logic [bdc_pkg::WORD_BITS-1:0] loc, loc2, mask, idx, value;
        int                            avail, pos, f, rem, reps;
        word_results.delete();
        avail  = (held_count > 34 ? 34 : held_count) + bdc_pkg::WORD_BITS;
        stream = {held_bits, item.compressed_word};
        pos    = 0;
        while (pos + 3 <= avail)
        begin
            prefix_bits = 3'(stream_field(stream, avail, pos, 3));
            prefix      = code_t'(prefix_bits);
            f           = pos + 3;
            // Padding throws away the rest of the current word.
            if (prefix == CODE_PAD)
            begin
                pos = avail;
                break;
            end
            if (pos + code_bits_len[prefix] > avail)
            begin
                break;
            end
            reps  = 1;
            value = '0;
            case (prefix)
                CODE_REPEAT:
                begin
                    reps  = int'(stream_field(stream, avail, f, 2)) + 1;
                    value = last_emitted;
                end
                CODE_MASK:
                begin
                    loc   = stream_field(stream, avail, f, 5);
                    mask  = stream_field(stream, avail, f + 5, 4);
                    idx   = stream_field(stream, avail, f + 9, 3);
                    value = dict_model[idx[2:0]] ^ ((mask << 28) >> loc);
                end
                CODE_ONE_FLIP:
                begin
                    loc   = stream_field(stream, avail, f, 5);
                    idx   = stream_field(stream, avail, f + 5, 3);
                    value = dict_model[idx[2:0]] ^ (32'h8000_0000 >> loc);
                end
                CODE_PAIR_FLIP:
                begin
                    loc   = stream_field(stream, avail, f, 5);
                    idx   = stream_field(stream, avail, f + 5, 3);
                    value = dict_model[idx[2:0]] ^ (32'hC000_0000 >> loc);
                end
                CODE_TWO_FLIP:
                begin
                    loc   = stream_field(stream, avail, f, 5);
                    loc2  = stream_field(stream, avail, f + 5, 5);
                    idx   = stream_field(stream, avail, f + 10, 3);
                    value = dict_model[idx[2:0]]
                            ^ ((32'h8000_0000 >> loc) | (32'h8000_0000 >> loc2));
                end
                CODE_DICT:
                begin
                    idx   = stream_field(stream, avail, f, 3);
                    value = dict_model[idx[2:0]];
                end
                default:
                begin
                    value = stream_field(stream, avail, f, bdc_pkg::WORD_BITS);
                end
            endcase
            repeat (reps)
            begin
                word_results.insert(word_results.size(),
                                    '{decoded_word: value, run_last: 1'b0});
            end
            last_emitted = value;
            pos += code_bits_len[prefix];
        end

        // Keep an incomplete tail unless this is the final word of the stream.
        rem = avail - pos;
        if (item.final_word || rem == 0 || rem > 34)
        begin
            held_bits  = '0;
            held_count = 0;
        end
        else
        begin
            held_bits  = stream[33:0] & ((34'd1 << rem) - 34'd1);
            held_count = rem;
        end
        if (word_results.size() > 0)
        begin
            word_results[word_results.size() - 1].run_last = 1'b1;
        end
    endtask

    // Offers one stream word after a random gap and queues what it should produce.
    task automatic offer_word(bdc_pkg::in_t item, bit pinned, int pin_count,
                              logic [bdc_pkg::WORD_BITS-1:0] pin_value);
        int gap;
        gap = $urandom_range(0, sender_gap_max);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do
            @(posedge clk);
        while (!in_ready);
        decode_stream_word(item);
        if (pinned)
        begin
            word_results.delete();
            repeat (pin_count)
            begin
                word_results.insert(word_results.size(),
                                    '{decoded_word: pin_value, run_last: 1'b0});
            end
            if (pin_count > 0)
            begin
                word_results[pin_count - 1].run_last = 1'b1;
            end
        end
        foreach (word_results[i])
        begin
            expected_words.insert(expected_words.size(), word_results[i]);
        end
    endtask

    task automatic write_register(logic [bdc_pkg::CFG_IDX_BITS-1:0] index,
                                  logic [bdc_pkg::WORD_BITS-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        if (index < bdc_pkg::DICT_ENTRIES)
        begin
            dict_model[index[2:0]] = value;
        end
    endtask

    // Stops offering, lets every expected word arrive, then lets the pipeline go quiet.
    task automatic drain_and_settle();
        in_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Watchdog on cycles in which neither channel moves a word.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            stalled_cycles <= 0;
        end
        else
        begin
            stalled_cycles <= stalled_cycles + 1;
        end
        if (stalled_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Receiver: random stalls, one long hold-off, and an in-order check of every word.
    initial
    begin : receiver
        int            stall;
        bit            held_off;
        bdc_pkg::out_t want;
        held_off = 1'b0;
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (!held_off && results_seen >= HOLD_OFF_AFTER)
            begin
                held_off = 1'b1;
                stall    = HOLD_OFF_CYCLES;
            end
            else
            begin
                stall = $urandom_range(0, receiver_stall_max);
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            if (expected_words.size() == 0)
            begin
                note_mismatch($sformatf("unexpected word %h", out_data.decoded_word));
            end
            else
            begin
                want = expected_words.pop_front();
                if (out_data.decoded_word !== want.decoded_word)
                begin
                    note_mismatch($sformatf("decoded_word %h, expected %h",
                                            out_data.decoded_word, want.decoded_word));
                end
                if (out_data.run_last !== want.run_last)
                begin
                    note_mismatch($sformatf("run_last %b, expected %b",
                                            out_data.run_last, want.run_last));
                end
            end
            results_seen++;
        end
    end

    // Stimulus: directed table, then phases of random streams under fresh dictionaries.
    initial
    begin : stimulus
        bdc_pkg::in_t                  item;
        code_t                         prefix;
        logic [bdc_pkg::WORD_BITS-1:0] word_bits;
        for (int k = 0; k < bdc_pkg::DICT_ENTRIES; k++)
        begin
            dict_model[k] = '0;
        end

        // After reset every dictionary entry is zero, so most results are plain to see.
        add_row('{{CODE_REPEAT, 2'b11, CODE_PAD, 24'h0}, 1'b0, 1'b1, 4, 32'h0});
        add_row('{{CODE_RAW, 29'h1FFF_FFFF}, 1'b0, 1'b1, 0, 32'h0});
        add_row('{{CODE_PAD, CODE_PAD, 26'h0}, 1'b0, 1'b1, 1, 32'hFFFF_FFFF});
        add_row('{{CODE_REPEAT, 2'b00, CODE_PAD, 24'h0}, 1'b0, 1'b1, 1, 32'hFFFF_FFFF});
        add_row('{{CODE_DICT, 3'd0, CODE_DICT, 3'd7, CODE_PAD, 17'h0},
                  1'b0, 1'b1, 2, 32'h0});
        add_row('{{CODE_ONE_FLIP, 5'd0, 3'd0, CODE_PAD, 18'h0},
                  1'b0, 1'b1, 1, 32'h8000_0000});
        add_row('{{CODE_ONE_FLIP, 5'd31, 3'd7, CODE_PAD, 18'h0},
                  1'b0, 1'b1, 1, 32'h0000_0001});
        // A pair of flips at the last position loses its second bit.
        add_row('{{CODE_PAIR_FLIP, 5'd31, 3'd0, CODE_PAD, 18'h0},
                  1'b0, 1'b1, 1, 32'h0000_0001});
        add_row('{{CODE_PAIR_FLIP, 5'd0, 3'd6, CODE_PAD, 18'h0},
                  1'b0, 1'b1, 1, 32'hC000_0000});
        // Mask bits that run past the end of the word are dropped.
        add_row('{{CODE_MASK, 5'd30, 4'hF, 3'd0, CODE_PAD, 14'h0},
                  1'b0, 1'b1, 1, 32'h0000_0003});
        add_row('{{CODE_MASK, 5'd29, 4'hF, 3'd1, CODE_PAD, 14'h0},
                  1'b0, 1'b1, 1, 32'h0000_0007});
        add_row('{{CODE_MASK, 5'd0, 4'hA, 3'd4, CODE_PAD, 14'h0},
                  1'b0, 1'b1, 1, 32'hA000_0000});
        // Two flips on the same position flip that bit once.
        add_row('{{CODE_TWO_FLIP, 5'd7, 5'd7, 3'd0, CODE_PAD, 13'h0},
                  1'b0, 1'b1, 1, 32'h0100_0000});
        add_row('{{CODE_TWO_FLIP, 5'd0, 5'd31, 3'd3, CODE_PAD, 13'h0},
                  1'b0, 1'b1, 1, 32'h8000_0001});
        // An incomplete code on the final word is thrown away.
        add_row('{{CODE_RAW, 29'h001_2345}, 1'b1, 1'b1, 0, 32'h0});
        add_row('{{CODE_DICT, 3'd2, CODE_PAD, 23'h0}, 1'b0, 1'b1, 1, 32'h0});
        // Fewer than three prefix bits are carried into the next word.
        add_row('{{CODE_DICT, 3'd0, CODE_DICT, 3'd1, CODE_DICT, 3'd2, CODE_DICT, 3'd3,
                   CODE_DICT, 3'd4, 2'b10}, 1'b0, 1'b1, 5, 32'h0});
        add_row('{{1'b1, 3'd3, CODE_PAD, 25'h0}, 1'b0, 1'b1, 1, 32'h0});
        add_row('{{{6{{CODE_REPEAT, 2'b11}}}, 2'b11}, 1'b0, 1'b1, 24, 32'h0});
        add_row('{32'hFFFF_FFFF, 1'b0, 1'b1, 0, 32'h0});
        add_row('{32'h0000_0000, 1'b0, 1'b1, 6, 32'h0});
        add_row('{32'h0000_0000, 1'b1, 1'b1, 6, 32'h0});
        add_row('{32'hFFFF_FFFF, 1'b1, 1'b1, 0, 32'h0});
        // An uncompressed word split across two stream words.
        add_row('{{CODE_RAW, 29'h0AB_CDEF}, 1'b0, 1'b0, 0, 32'h0});
        add_row('{{CODE_DICT, CODE_PAD, 26'h0}, 1'b0, 1'b0, 0, 32'h0});

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        foreach (rows[i])
        begin
            item = '{compressed_word: rows[i].word, final_word: rows[i].fin};
            offer_word(item, rows[i].pinned, rows[i].pin_count, rows[i].pin_value);
        end

        for (int phase = 0; phase < PHASES; phase++)
        begin
            drain_and_settle();
            sender_gap_max     = phase_gap[phase];
            receiver_stall_max = phase_stall[phase];

            // New dictionary, plus one write to an index that must be ignored.
            for (int k = 0; k < bdc_pkg::DICT_ENTRIES; k++)
            begin
                case (phase_fill[phase])
                    FILL_ONES:    word_bits = '1;
                    FILL_ZEROS:   word_bits = '0;
                    FILL_STRIPES: word_bits = k[0] ? 32'hAAAA_AAAA : 32'h5555_5555;
                    default:      word_bits = $urandom;
                endcase
                write_register(REG_DICT_BASE + k[bdc_pkg::CFG_IDX_BITS-1:0], word_bits);
            end
            write_register(REG_FIRST_UNUSED
                           + bdc_pkg::CFG_IDX_BITS'($urandom_range(0, 7)), $urandom);
            cfg_we <= 1'b0;

            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                if ($urandom_range(0, 11) == 0)
                begin
                    // Noise word: knocks the decoder out of step with the code stream.
                    word_bits = $urandom;
                end
                else
                begin
                    // Well-formed codes with random content, cut into 32-bit words.
                    while (stream_bits.size() < bdc_pkg::WORD_BITS)
                    begin
                        prefix = code_t'($urandom_range(0, 7));
                        if (prefix == CODE_PAD
                            && stream_bits.size() > bdc_pkg::WORD_BITS - 3)
                        begin
                            prefix = CODE_DICT;
                        end
                        for (int b = 2; b >= 0; b--)
                        begin
                            stream_bits.insert(stream_bits.size(), prefix[b]);
                        end
                        for (int b = code_bits_len[prefix] - 4; b >= 0; b--)
                        begin
                            stream_bits.insert(stream_bits.size(),
                                               1'($urandom_range(0, 1)));
                        end
                        if (prefix == CODE_PAD)
                        begin
                            while (stream_bits.size() < bdc_pkg::WORD_BITS)
                            begin
                                stream_bits.insert(stream_bits.size(),
                                                   1'($urandom_range(0, 1)));
                            end
                        end
                    end
                    for (int b = 0; b < bdc_pkg::WORD_BITS; b++)
                    begin
                        word_bits = {word_bits[bdc_pkg::WORD_BITS-2:0],
                                     stream_bits.pop_front()};
                    end
                end
                item = '{compressed_word: word_bits, final_word: ($urandom_range(0, 15) == 0)};
                if (item.final_word)
                begin
                    stream_bits.delete();
                end
                offer_word(item, 1'b0, 0, '0);
            end
        end

        drain_and_settle();
        if (expected_words.size() != 0)
        begin
            note_mismatch($sformatf("%0d words never arrived", expected_words.size()));
        end
        if (mismatch_count == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
